// ----- hdl/orientation_zone_classifier_core_macros.svh -----
// assertion macros shared by the orientation zone classifier rtl
`ifndef ORIENTATION_ZONE_CLASSIFIER_CORE_MACROS_SVH
`define ORIENTATION_ZONE_CLASSIFIER_CORE_MACROS_SVH

// clocked property check, quiet while reset is asserted
`define OZC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ozc assertion failed");

// same-cycle implication
`define OZC_ASSERT_IMP(lbl, ante, cons) \
  `OZC_ASSERT(lbl, (ante) |-> (cons))

`endif

// ----- hdl/ozc_pkg.sv -----
// types and constants of the orientation zone classifier
package ozc_pkg;

  localparam int CompW    = 16;           // q1.14 component
  localparam int FracW    = 14;
  localparam int HamW     = 2 * CompW + 2; // sum of four component products
  localparam int NormW    = 30;           // squared norm of a saturated vector
  localparam int DotW     = 31;           // signed dot product
  localparam int ProdW    = 2 * NormW;    // product of two squared norms
  localparam int OpW      = 32;           // shared multiplier operand
  localparam int AccW     = 80;           // accumulator
  localparam int ZoneW    = 3;
  localparam int MaxSlots = 7;
  localparam int ShMid    = 16;
  localparam int ShHigh   = 30;

  localparam int InDataW  = 4 * CompW;
  localparam int OutDataW = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic signed [CompW-1:0] Q14One     = CompW'(16384);
  localparam logic [CompW-1:0]        CosSqReset = CompW'(57870);
  localparam logic [ZoneW-1:0]        NoZone     = ZoneW'(7);
  localparam logic [AccW-1:0]         RoundBias  = AccW'(1) << (FracW - 1);

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_16 = 2'd1,
    SH_30 = 2'd2
  } ozc_shift_e;

  typedef enum logic [2:0] {
    DST_X   = 3'd0,
    DST_Y   = 3'd1,
    DST_Z   = 3'd2,
    DST_NV  = 3'd3,
    DST_D   = 3'd4,
    DST_P   = 3'd5,
    DST_CMP = 3'd6
  } ozc_dest_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_W = 3'd0,
    REG_ORIGIN_X = 3'd1,
    REG_ORIGIN_Y = 3'd2,
    REG_ORIGIN_Z = 3'd3,
    REG_COS_SQ   = 3'd4
  } ozc_reg_e;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_CAPTURE = 1'b1
  } ozc_oper_e;

  typedef struct packed {
    logic       valid;
    logic       sub;
    logic       clr;
    logic       rnd;
    ozc_shift_e sh;
    logic       last;
    ozc_dest_e  dest;
  } ozc_ctl_t;

  typedef struct packed {
    ozc_ctl_t       ctl;
    logic [OpW-1:0] a;
    logic [OpW-1:0] b;
  } ozc_op_t;

  typedef struct packed {
    logic      valid;
    ozc_dest_e dest;
  } ozc_done_t;

endpackage

// ----- hdl/orientation_zone_classifier_core.sv -----
// orientation zone classifier: quaternion rotate, then angle test against calibrated zones
//
//   channel   dir  signals                                   payload
//   s_axis    in   tvalid tready tdata[63:0] tuser[0:0]      sample quaternion, operation
//   m_axis    out  tvalid tready tdata[7:0]  tuser[0:0]      zone, captured slot, captured
//   cfg       in   valid ready index[2:0] data[15:0]         origin quaternion, cos^2 threshold
//
// a sample beat examines the calibrated slots in order up to and including the first match
// (at most seven); every product goes through the one 32x32 multiplier of ozc_mac, one
// issue per cycle within a phase, the sequencer waiting for the unit to drain between phases.
// a capture beat goes straight to the final state. the input side is ready only while idle.
// a finished result sits in the output register; a new beat may be taken meanwhile,
// its result waits in the final state until the register is free.
// reset restores the origin to identity, the threshold to twenty degrees, empties all slots.
`include "orientation_zone_classifier_core_macros.svh"

module orientation_zone_classifier_core #(
  parameter int ZONE_COUNT = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave side: quat_w, quat_x, quat_y, quat_z (16 bits each, from bit 0 up)
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ozc_pkg::InDataW-1:0]      s_axis_tdata,
  // operation: 0 sample, 1 capture
  input  logic [0:0]                       s_axis_tuser,
  // master side: zone [2:0], captured_slot [5:3], zero fill [7:6]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ozc_pkg::OutDataW-1:0]     m_axis_tdata,
  // captured
  output logic [0:0]                       m_axis_tuser,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ozc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ozc_pkg::CfgDataW-1:0]     cfg_data_i
);
  import ozc_pkg::*;

  localparam int ActiveSlots = (ZONE_COUNT < MaxSlots) ? ZONE_COUNT : MaxSlots;
  localparam int IdxW        = (ActiveSlots > 1) ? $clog2(ActiveSlots) : 1;
  localparam logic [ZoneW-1:0] SlotLimit = ZoneW'(ActiveSlots);

  // index of the last step of each sequencer phase
  localparam logic [3:0] HamLast  = 4'd11;
  localparam logic [3:0] NormLast = 4'd2;
  localparam logic [3:0] DotLast  = 4'd3;
  localparam logic [3:0] CmpLast  = 4'd2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HAM   = 10'b0000000010,  // rotate the sample by the origin
    S_HWAIT = 10'b0000000100,
    S_NORM  = 10'b0000001000,  // squared norm of the reference vector
    S_NWAIT = 10'b0000010000,
    S_DOT   = 10'b0000100000,  // dot product and norm product for one slot
    S_DWAIT = 10'b0001000000,
    S_CMP   = 10'b0010000000,  // d^2 * 2^16 - thr * nv * ns
    S_CWAIT = 10'b0100000000,
    S_FIN   = 10'b1000000000   // hand the result to the output register
  } ozc_state_e;

  ozc_state_e state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [ZoneW-1:0] slot_q, slot_d;

  // configuration
  logic signed [CompW-1:0] org_q [4];
  logic [CompW-1:0]        thr_q;

  // sample and reference state
  logic signed [CompW-1:0] quat_q [4];
  logic signed [CompW-1:0] v_q [3];
  logic [NormW-1:0]        nv_q;
  logic [ZoneW-1:0]        next_slot_q;
  logic [ZoneW-1:0]        cur_zone_q;

  // calibrated slots with their squared norms, filled in order
  logic signed [CompW-1:0] sv_q [ActiveSlots][3];
  logic [NormW-1:0]        sns_q [ActiveSlots];

  // intermediate results
  logic signed [DotW-1:0]  d_q;
  logic [ProdW-1:0]        p_q;
  logic                    match_q;

  // pending and registered result
  logic                    res_cap_q;
  logic [ZoneW-1:0]        res_slot_q;
  logic                    out_valid_q, out_cap_q;
  logic [ZoneW-1:0]        out_zone_q, out_slot_q;

  logic                    in_acc, out_free;
  logic                    zone_load;
  logic [ZoneW-1:0]        zone_val;
  logic [IdxW-1:0]         sidx, widx;

  ozc_op_t                 mac_op;
  logic signed [AccW-1:0]  mac_acc;
  ozc_done_t               mac_done;
  logic                    mac_busy;

  logic [1:0]              a_idx, grp, b_idx;

  function automatic logic signed [CompW-1:0] sat_q14(input logic signed [AccW-1:0] acc);
    logic signed [HamW-FracW-1:0] r;
    r = acc[HamW-1:FracW];
    if (r > (HamW-FracW)'(Q14One)) begin
      sat_q14 = Q14One;
    end else if (r < -(HamW-FracW)'(Q14One)) begin
      sat_q14 = -Q14One;
    end else begin
      sat_q14 = r[CompW-1:0];
    end
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_acc          = s_axis_tvalid && s_axis_tready;
  assign out_free        = !out_valid_q || m_axis_tready;
  assign sidx            = slot_q[IdxW-1:0];
  assign widx            = next_slot_q[IdxW-1:0];

  // hamilton product r = q * o: component a_idx of q meets component a_idx ^ (grp + 1) of o
  assign a_idx = cnt_q[1:0];
  assign grp   = cnt_q[3:2];
  assign b_idx = a_idx ^ (grp + 2'd1);

  // sequencer and operand selection
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    slot_d    = slot_q;
    zone_load = 1'b0;
    zone_val  = NoZone;
    mac_op    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d   = '0;
          state_d = (ozc_oper_e'(s_axis_tuser[0]) == OP_CAPTURE) ? S_FIN : S_HAM;
        end
      end
      S_HAM: begin
        mac_op.ctl.valid = 1'b1;
        mac_op.ctl.rnd   = 1'b1;
        mac_op.ctl.clr   = (a_idx == 2'd0);
        mac_op.ctl.last  = (a_idx == 2'd3);
        mac_op.ctl.sub   = ((grp == 2'd0) && (a_idx == 2'd3)) ||
                           ((grp == 2'd1) && (a_idx == 2'd1)) ||
                           ((grp == 2'd2) && (a_idx == 2'd2));
        mac_op.ctl.sh    = SH_0;
        mac_op.ctl.dest  = ozc_dest_e'({1'b0, grp});
        mac_op.a         = OpW'(quat_q[a_idx]);
        mac_op.b         = OpW'(org_q[b_idx]);
        cnt_d            = cnt_q + 4'd1;
        if (cnt_q == HamLast) begin
          cnt_d   = '0;
          state_d = S_HWAIT;
        end
      end
      S_HWAIT: begin
        if (!mac_busy) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        mac_op.ctl.valid = 1'b1;
        mac_op.ctl.clr   = (cnt_q == '0);
        mac_op.ctl.last  = (cnt_q == NormLast);
        mac_op.ctl.sh    = SH_0;
        mac_op.ctl.dest  = DST_NV;
        mac_op.a         = OpW'(v_q[cnt_q[1:0]]);
        mac_op.b         = OpW'(v_q[cnt_q[1:0]]);
        cnt_d            = cnt_q + 4'd1;
        if (cnt_q == NormLast) begin
          cnt_d   = '0;
          state_d = S_NWAIT;
        end
      end
      S_NWAIT: begin
        if (!mac_busy) begin
          slot_d = '0;
          if (next_slot_q == '0) begin
            zone_load = 1'b1;
            state_d   = S_FIN;
          end else begin
            state_d = S_DOT;
          end
        end
      end
      S_DOT: begin
        mac_op.ctl.valid = 1'b1;
        mac_op.ctl.sh    = SH_0;
        if (cnt_q == DotLast) begin
          // norm product, independent of the dot product
          mac_op.ctl.clr  = 1'b1;
          mac_op.ctl.last = 1'b1;
          mac_op.ctl.dest = DST_P;
          mac_op.a        = OpW'(nv_q);
          mac_op.b        = OpW'(sns_q[sidx]);
          cnt_d           = '0;
          state_d         = S_DWAIT;
        end else begin
          mac_op.ctl.clr  = (cnt_q == '0);
          mac_op.ctl.last = (cnt_q == DotLast - 4'd1);
          mac_op.ctl.dest = DST_D;
          mac_op.a        = OpW'(v_q[cnt_q[1:0]]);
          mac_op.b        = OpW'(sv_q[sidx][cnt_q[1:0]]);
          cnt_d           = cnt_q + 4'd1;
        end
      end
      S_DWAIT: begin
        if (!mac_busy) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        mac_op.ctl.valid = 1'b1;
        mac_op.ctl.dest  = DST_CMP;
        mac_op.b         = OpW'(thr_q);
        case (cnt_q[1:0])
          2'd0: begin
            mac_op.ctl.clr = 1'b1;
            mac_op.ctl.sh  = SH_16;
            mac_op.a       = OpW'(d_q);
            mac_op.b       = OpW'(d_q);
          end
          2'd1: begin
            mac_op.ctl.sub = 1'b1;
            mac_op.ctl.sh  = SH_30;
            mac_op.a       = OpW'(p_q[ProdW-1:NormW]);
          end
          default: begin
            mac_op.ctl.sub  = 1'b1;
            mac_op.ctl.last = 1'b1;
            mac_op.ctl.sh   = SH_0;
            mac_op.a        = OpW'(p_q[NormW-1:0]);
          end
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == CmpLast) begin
          cnt_d   = '0;
          state_d = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (!mac_busy) begin
          if (match_q) begin
            zone_load = 1'b1;
            zone_val  = slot_q;
            state_d   = S_FIN;
          end else if (slot_q + ZoneW'(1) == next_slot_q) begin
            zone_load = 1'b1;
            state_d   = S_FIN;
          end else begin
            slot_d  = slot_q + ZoneW'(1);
            state_d = S_DOT;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  ozc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (mac_acc),
    .done_o (mac_done),
    .busy_o (mac_busy)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      slot_q      <= '0;
      next_slot_q <= '0;
      cur_zone_q  <= NoZone;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      slot_q  <= slot_d;
      if (zone_load) begin
        cur_zone_q <= zone_val;
      end
      if (in_acc && (ozc_oper_e'(s_axis_tuser[0]) == OP_CAPTURE) &&
          (next_slot_q < SlotLimit)) begin
        next_slot_q <= next_slot_q + ZoneW'(1);
      end
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= Q14One;
      org_q[1] <= '0;
      org_q[2] <= '0;
      org_q[3] <= '0;
      thr_q    <= CosSqReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ozc_reg_e'(cfg_index_i))
        REG_ORIGIN_W: org_q[0] <= $signed(cfg_data_i);
        REG_ORIGIN_X: org_q[1] <= $signed(cfg_data_i);
        REG_ORIGIN_Y: org_q[2] <= $signed(cfg_data_i);
        REG_ORIGIN_Z: org_q[3] <= $signed(cfg_data_i);
        REG_COS_SQ:   thr_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // reference vector and its norm, zero until the first sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= '0;
      v_q[1] <= '0;
      v_q[2] <= '0;
      nv_q   <= '0;
    end else if (mac_done.valid) begin
      case (mac_done.dest)
        DST_X:   v_q[0] <= sat_q14(mac_acc);
        DST_Y:   v_q[1] <= sat_q14(mac_acc);
        DST_Z:   v_q[2] <= sat_q14(mac_acc);
        DST_NV:  nv_q   <= mac_acc[NormW-1:0];
        default: ;
      endcase
    end
  end

  // per-slot intermediates; match needs a positive dot and a nonnegative difference
  always_ff @(posedge clk_i) begin
    if (mac_done.valid) begin
      case (mac_done.dest)
        DST_D:   d_q     <= mac_acc[DotW-1:0];
        DST_P:   p_q     <= mac_acc[ProdW-1:0];
        DST_CMP: match_q <= !d_q[DotW-1] && (d_q != '0) && !mac_acc[AccW-1];
        default: ;
      endcase
    end
  end

  // sample capture, slot writes and the pending result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (ozc_oper_e'(s_axis_tuser[0]) == OP_CAPTURE) begin
        if (next_slot_q < SlotLimit) begin
          sv_q[widx][0] <= v_q[0];
          sv_q[widx][1] <= v_q[1];
          sv_q[widx][2] <= v_q[2];
          sns_q[widx]   <= nv_q;
          res_cap_q     <= 1'b1;
          res_slot_q    <= next_slot_q;
        end else begin
          res_cap_q  <= 1'b0;
          res_slot_q <= '0;
        end
      end else begin
        quat_q[0]  <= s_axis_tdata[CompW-1:0];
        quat_q[1]  <= s_axis_tdata[2*CompW-1:CompW];
        quat_q[2]  <= s_axis_tdata[3*CompW-1:2*CompW];
        quat_q[3]  <= s_axis_tdata[4*CompW-1:3*CompW];
        res_cap_q  <= 1'b0;
        res_slot_q <= '0;
      end
    end
    if ((state_q == S_FIN) && out_free) begin
      out_zone_q <= cur_zone_q;
      out_cap_q  <= res_cap_q;
      out_slot_q <= res_slot_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 2 * ZoneW){1'b0}}, out_slot_q, out_zone_q};
  assign m_axis_tuser  = out_cap_q;

  // the shared unit has drained whenever a new beat can be taken
  `OZC_ASSERT_IMP(a_idle_drained, s_axis_tready, !mac_busy)
  // a reported zone is always a filled slot or none
  `OZC_ASSERT_IMP(a_zone_filled, m_axis_tvalid, (out_zone_q == NoZone) || (out_zone_q < next_slot_q))
  // a reported capture names a slot that is now filled
  `OZC_ASSERT_IMP(a_cap_filled, m_axis_tvalid && out_cap_q, out_slot_q < next_slot_q)
  // the fill count never passes the slot count
  `OZC_ASSERT_IMP(a_fill_bound, 1'b1, next_slot_q <= SlotLimit)

endmodule

// ----- hdl/ozc_mac.sv -----
// shared multiply-accumulate unit: registered product, then shifted accumulate
module ozc_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ozc_pkg::ozc_op_t                    op_i,
  output logic signed [ozc_pkg::AccW-1:0]     acc_o,
  output ozc_pkg::ozc_done_t                  done_o,
  output logic                                busy_o
);
  import ozc_pkg::*;

  logic signed [OpW-1:0]   mul_a;
  logic signed [OpW-1:0]   mul_b;
  logic signed [2*OpW-1:0] prod_q;
  ozc_ctl_t                ctl_q;
  ozc_done_t               done_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW-1:0]  term, term_sh, base;

  assign mul_a = $signed(op_i.a);
  assign mul_b = $signed(op_i.b);

  always_ff @(posedge clk_i) begin
    if (op_i.ctl.valid) begin
      prod_q <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_q <= '0;
    end else begin
      ctl_q        <= op_i.ctl;
      done_q.valid <= ctl_q.valid && ctl_q.last;
      done_q.dest  <= ctl_q.dest;
    end
  end

  always_comb begin
    term = AccW'(prod_q);
    case (ctl_q.sh)
      SH_16:   term_sh = term <<< ShMid;
      SH_30:   term_sh = term <<< ShHigh;
      default: term_sh = term;
    endcase
    if (ctl_q.clr) begin
      base = ctl_q.rnd ? $signed(RoundBias) : '0;
    end else begin
      base = acc_q;
    end
    acc_d = ctl_q.sub ? (base - term_sh) : (base + term_sh);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;
  assign busy_o = ctl_q.valid | done_q.valid;

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the orientation zone classifier core
`timescale 1ns / 1ps

module testbench;
  import ozc_pkg::*;

  localparam int ZoneCount   = 7;
  localparam int ActiveSlots = (ZoneCount < MaxSlots) ? ZoneCount : MaxSlots;
  localparam int NumPhases   = 6;
  localparam int PhaseItems  = 275;
  localparam int SettleCycles = 16;   // idle gap before register writes
  localparam int EndPause    = 200;   // longer than the worst sample latency
  localparam int QuietLimit  = 5000;  // cycles without any beat before giving up

  localparam bit Typed   = 1'b1;      // directed row carries its own result
  localparam bit Modeled = 1'b0;      // directed row is checked against the predictor

  localparam logic [CfgIdxW-1:0] RegSpareFirst = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegSpareLast  = '1;

  typedef struct packed {
    logic signed [CompW-1:0] z;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] w;
  } quat_t;  // packs straight onto tdata, w in the low bits

  typedef struct packed {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [ZoneW-1:0] zone;
    logic             captured;
    logic [ZoneW-1:0] slot;
  } result_t;

  typedef struct packed {
    ozc_oper_e               oper;
    logic signed [CompW-1:0] w;
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
    bit                      typed;
    logic [ZoneW-1:0]        zone;
    logic                    captured;
    logic [ZoneW-1:0]        slot;
  } dir_row_t;

  typedef struct packed {
    quat_t           origin;
    logic [CompW-1:0] cos_sq;
  } setting_t;

  // oper, w, x, y, z, typed, zone, captured, slot
  localparam dir_row_t DirRows [24] = '{
    '{OP_SAMPLE,  16384,      0,      0,      0, Typed,   NoZone, 1'b0, 3'd0}, // zero reference
    '{OP_SAMPLE,      0,  16384,      0,      0, Typed,   NoZone, 1'b0, 3'd0}, // all slots empty
    '{OP_CAPTURE,     0,      0,      0,      0, Typed,   NoZone, 1'b1, 3'd0}, // +x into slot 0
    '{OP_SAMPLE,      0,  16384,      0,      0, Typed,   3'd0,   1'b0, 3'd0},
    '{OP_SAMPLE,      0, -16384,      0,      0, Typed,   NoZone, 1'b0, 3'd0}, // opposite
    '{OP_SAMPLE,      0,      0,  16384,      0, Typed,   NoZone, 1'b0, 3'd0}, // orthogonal
    '{OP_CAPTURE,    -1,     -1,     -1,     -1, Typed,   NoZone, 1'b1, 3'd1}, // +y into slot 1
    '{OP_SAMPLE, -32768,  32767, -32768,  32767, Modeled, 3'd0,   1'b0, 3'd0}, // saturating
    '{OP_CAPTURE,     0,      0,      0,      0, Modeled, 3'd0,   1'b0, 3'd0},
    '{OP_SAMPLE,      0,      0,      0,      0, Typed,   NoZone, 1'b0, 3'd0},
    '{OP_CAPTURE,     0,      0,      0,      0, Typed,   NoZone, 1'b1, 3'd3}, // zero slot
    '{OP_SAMPLE,      0,      0,      0, -16384, Modeled, 3'd0,   1'b0, 3'd0},
    '{OP_CAPTURE,     0,      0,      0,      0, Modeled, 3'd0,   1'b0, 3'd0},
    '{OP_SAMPLE,      0,  11585,  11585,      0, Modeled, 3'd0,   1'b0, 3'd0},
    '{OP_CAPTURE,     0,      0,      0,      0, Modeled, 3'd0,   1'b0, 3'd0},
    '{OP_SAMPLE,      0,      0, -12000,   9000, Modeled, 3'd0,   1'b0, 3'd0},
    '{OP_CAPTURE,     0,      0,      0,      0, Modeled, 3'd0,   1'b0, 3'd0}, // last free slot
    '{OP_CAPTURE,  4660,  -4660,  32767, -32768, Modeled, 3'd0,   1'b0, 3'd0}, // table full
    '{OP_SAMPLE,  16384,  16384,  16384,  16384, Modeled, 3'd0,   1'b0, 3'd0},
    '{OP_SAMPLE,      0,  16000,   2000,      0, Modeled, 3'd0,   1'b0, 3'd0},
    '{OP_SAMPLE,      0,      0,  15000,  -6000, Modeled, 3'd0,   1'b0, 3'd0},
    '{OP_SAMPLE, -16384, -16384, -16384, -16384, Modeled, 3'd0,   1'b0, 3'd0},
    '{OP_SAMPLE,      1,      1,      0,      0, Modeled, 3'd0,   1'b0, 3'd0}, // tiny vector
    '{OP_CAPTURE,     0,      0,      0,      0, Modeled, 3'd0,   1'b0, 3'd0}
  };

  // register settings per phase; the last phase draws its own at random
  localparam setting_t Settings [NumPhases-1] = '{
    '{'{w: 16384, x: 0, y: 0, z: 0}, CosSqReset},
    '{'{w: 11585, x: 0, y: 0, z: 11585}, 16'd0},
    '{'{w: -16384, x: 0, y: 0, z: 0}, 16'hFFFF},
    '{'{w: 8192, x: 8192, y: -8192, z: 8192}, 16'd49152},
    '{'{w: 32767, x: -32768, y: 16384, z: -16384}, 16'd1}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  orientation_zone_classifier_core #(
    .ZONE_COUNT(ZoneCount)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor state and its copy of the registers
  quat_t            origin = '{w: 16384, x: 0, y: 0, z: 0};
  logic [CompW-1:0] cos_sq = CosSqReset;
  vec_t             zone_vec [ActiveSlots];
  vec_t             last_ref = '0;
  int unsigned      slots_filled = 0;
  logic [ZoneW-1:0] cur_zone = NoZone;

  result_t     awaited_results [$];
  int unsigned mismatch_count = 0;
  int unsigned sample_count = 0;
  int unsigned capture_count = 0;
  int unsigned hit_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    foreach (zone_vec[i]) zone_vec[i] = '0;
  end

  function automatic logic signed [CompW-1:0] sat_q14(longint v);
    if (v > longint'(Q14One)) return Q14One;
    if (v < -longint'(Q14One)) return -Q14One;
    return CompW'(v);
  endfunction

  // q2.28 sum down to q1.14, half up, then clamp to +-1
  function automatic logic signed [CompW-1:0] round_q14(longint acc);
    return sat_q14((acc + (longint'(1) << (FracW - 1))) >>> FracW);
  endfunction

  function automatic quat_t hamilton(quat_t a, quat_t b);
    longint aw, ax, ay, az, bw, bx, by, bz;
    quat_t  r;
    aw = $signed(a.w); ax = $signed(a.x); ay = $signed(a.y); az = $signed(a.z);
    bw = $signed(b.w); bx = $signed(b.x); by = $signed(b.y); bz = $signed(b.z);
    r.w = round_q14(aw * bw - ax * bx - ay * by - az * bz);
    r.x = round_q14(aw * bx + ax * bw + ay * bz - az * by);
    r.y = round_q14(aw * by - ax * bz + ay * bw + az * bx);
    r.z = round_q14(aw * bz + ax * by - ay * bx + az * bw);
    return r;
  endfunction

  // angle test without acos: d > 0 and d^2 * 2^16 >= cos^2 * |v|^2 * |s|^2
  function automatic bit in_zone(vec_t v, vec_t s);
    longint     dot, nv, ns;
    logic [127:0] lhs, rhs;
    dot = longint'($signed(v.x)) * $signed(s.x) + longint'($signed(v.y)) * $signed(s.y)
        + longint'($signed(v.z)) * $signed(s.z);
    if (dot <= 0) return 1'b0;
    nv = longint'($signed(v.x)) * $signed(v.x) + longint'($signed(v.y)) * $signed(v.y)
       + longint'($signed(v.z)) * $signed(v.z);
    ns = longint'($signed(s.x)) * $signed(s.x) + longint'($signed(s.y)) * $signed(s.y)
       + longint'($signed(s.z)) * $signed(s.z);
    lhs = 128'(dot);
    lhs = (lhs * lhs) << 16;
    rhs = 128'(nv) * 128'(ns) * 128'(cos_sq);
    return lhs >= rhs;
  endfunction

  // one beat through the predictor: capture fills the next free slot, if any, sample reclassifies
  function automatic result_t zone_step(ozc_oper_e oper, quat_t q);
    result_t res;
    quat_t   r;
    res = '0;
    if (oper == OP_CAPTURE) begin
      capture_count++;
      if (slots_filled < ActiveSlots) begin
        zone_vec[slots_filled] = last_ref;
        res.captured = 1'b1;
        res.slot = ZoneW'(slots_filled);
        slots_filled++;
      end
    end else begin
      sample_count++;
      r = hamilton(q, origin);
      last_ref = '{x: r.x, y: r.y, z: r.z};
      cur_zone = NoZone;
      for (int k = 0; k < ActiveSlots; k++) begin
        if (cur_zone == NoZone && in_zone(last_ref, zone_vec[k])) cur_zone = ZoneW'(k);
      end
      if (cur_zone != NoZone) hit_count++;
    end
    res.zone = cur_zone;
    return res;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // sender: optional idle cycles, then hold the beat until it is taken
  task automatic send_beat(ozc_oper_e oper, quat_t q, bit typed, result_t want);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    res = zone_step(oper, q);
    awaited_results.push_back(typed ? want : res);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= oper;
    s_axis_tdata  <= q;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ORIGIN_W: origin.w = val;
      REG_ORIGIN_X: origin.x = val;
      REG_ORIGIN_Y: origin.y = val;
      REG_ORIGIN_Z: origin.z = val;
      REG_COS_SQ:   cos_sq = val;
      default: ;
    endcase
  endtask

  // wait until every result is back and the core has gone quiet
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mostly samples aimed near a calibrated vector with varying spread, so the
  // angle test lands on both sides of the threshold; the rest is captures and noise
  task automatic pick_random_beat(output ozc_oper_e oper, output quat_t q);
    int unsigned pick, slot;
    longint      spread;
    quat_t       tgt, conj_origin;
    pick = $urandom_range(99);
    oper = OP_SAMPLE;
    if (pick < 12) begin
      oper = OP_CAPTURE;
      q = quat_t'({$urandom(), $urandom()});
    end else if (pick < 70 && slots_filled > 0) begin
      slot = $urandom_range(slots_filled - 1);
      case ($urandom_range(3))
        0: spread = 0;
        1: spread = 300;
        2: spread = 2500;
        default: spread = 9000;
      endcase
      tgt.w = CompW'($urandom());
      tgt.x = sat_q14(zone_vec[slot].x + longint'($urandom_range(2 * spread)) - spread);
      tgt.y = sat_q14(zone_vec[slot].y + longint'($urandom_range(2 * spread)) - spread);
      tgt.z = sat_q14(zone_vec[slot].z + longint'($urandom_range(2 * spread)) - spread);
      // postmultiply by the conjugate so that q * origin points along the target
      conj_origin = '{w: origin.w, x: -origin.x, y: -origin.y, z: -origin.z};
      q = hamilton(tgt, conj_origin);
    end else if (pick < 90) begin
      q.w = CompW'(int'($urandom_range(32768)) - 16384);
      q.x = CompW'(int'($urandom_range(32768)) - 16384);
      q.y = CompW'(int'($urandom_range(32768)) - 16384);
      q.z = CompW'(int'($urandom_range(32768)) - 16384);
    end else begin
      q = quat_t'({$urandom(), $urandom()});
    end
  endtask

  initial begin
    quat_t     q;
    result_t   want;
    ozc_oper_e oper;
    setting_t  set;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 22;
    recv_stall_pct = 84;
    // directed rows run with the reset register values
    foreach (DirRows[i]) begin
      q    = '{w: DirRows[i].w, x: DirRows[i].x, y: DirRows[i].y, z: DirRows[i].z};
      want = '{zone: DirRows[i].zone, captured: DirRows[i].captured, slot: DirRows[i].slot};
      send_beat(DirRows[i].oper, q, DirRows[i].typed, want);
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      if (phase < 2) begin
        send_idle_pct  = 22;
        recv_stall_pct = 84;
      end else if (phase < 4) begin
        send_idle_pct  = 84;
        recv_stall_pct = 22;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (phase < NumPhases - 1) begin
        set = Settings[phase];
      end else begin
        set.origin = quat_t'({$urandom(), $urandom()});
        set.cos_sq = CompW'($urandom());
      end
      write_reg(REG_ORIGIN_W, set.origin.w);
      write_reg(REG_ORIGIN_X, set.origin.x);
      write_reg(REG_ORIGIN_Y, set.origin.y);
      write_reg(REG_ORIGIN_Z, set.origin.z);
      write_reg(REG_COS_SQ, set.cos_sq);
      // indexes past the register map must leave everything unchanged
      write_reg(CfgIdxW'($urandom_range(RegSpareLast, RegSpareFirst)), CfgDataW'($urandom()));
      cfg_valid_i <= 1'b0;
      repeat (PhaseItems) begin
        pick_random_beat(oper, q);
        send_beat(oper, q, Modeled, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (EndPause) @(posedge clk_i);

    $display("covered %0d samples and %0d capture beats over %0d register settings",
             sample_count, capture_count, NumPhases + 1);
    $display("%0d samples fell inside a calibrated zone, %0d outside every zone",
             hit_count, sample_count - hit_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side: random backpressure, compare each beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing outstanding: tdata %h tuser %h",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("zone", want.zone, m_axis_tdata[ZoneW-1:0]);
        check_field("captured_slot", want.slot, m_axis_tdata[2*ZoneW-1:ZoneW]);
        check_field("captured", want.captured, m_axis_tuser[0]);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles in which no channel moves a beat
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $error("no beat accepted for %0d cycles, %0d results outstanding",
             quiet_cycles, awaited_results.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ozc_pkg.sv
hdl/ozc_mac.sv
hdl/orientation_zone_classifier_core.sv
dv/testbench.sv
